// ===== hw/rtl/bracket_framed_packet_receiver_top_assert.svh =====
// assertion macros used by the packet receiver controller
`ifndef BRACKET_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH
`define BRACKET_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bfpr_pkg.sv =====
// shared constants and controller/datapath interface types of the packet receiver
package bfpr_pkg;

	// default size of the packet store
	localparam int BUFFER_DEPTH_DEF = 32;

	// framing characters
	localparam logic [7:0] CH_OPEN_NOTE   = 8'h5B; // [
	localparam logic [7:0] CH_OPEN_ADMIN  = 8'h7B; // {
	localparam logic [7:0] CH_OPEN_INSTR  = 8'h28; // (
	localparam logic [7:0] CH_CLOSE_NOTE  = 8'h5D; // ]
	localparam logic [7:0] CH_CLOSE_ADMIN = 8'h7D; // }
	localparam logic [7:0] CH_CLOSE_INSTR = 8'h29; // )
	localparam logic [7:0] CH_DOT         = 8'h2E; // . carried as plain data
	localparam logic [7:0] CH_ZERO        = 8'h30; // 0

	// packet kinds
	localparam logic [1:0] KIND_NOTE  = 2'd0;
	localparam logic [1:0] KIND_ADMIN = 2'd1;
	localparam logic [1:0] KIND_INSTR = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W   = 2;
	localparam logic [1:0] REG_ID_MASK = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;

	localparam logic [15:0] ID_MASK_RESET = 16'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic take;        // input transaction accepted
		logic start;       // opener seen, begin a packet
		logic store;       // write byte into the store
		logic clear_fill;  // drop partial packet
		logic finish;      // latch packet summary for emission
		logic rd_issue;    // read next payload byte
		logic out_load;    // load the output register
		logic k_inc;       // advance payload index
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_tick;
		logic is_opener;
		logic closes;       // closer matching the open bracket
		logic full;
		logic timeout_hit;
		logic pkt_ok;       // id byte present, digit valid, mask bit set
		logic empty;        // no payload bytes
		logic last_res;     // current result is the final one
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/bfpr_ram.sv =====
// generic single write port ram with registered read
module bfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/bfpr_datapath.sv =====
// datapath: config registers, idle timer, fill counter, packet store and output register
module bfpr_datapath #(
	parameter int BUFFER_DEPTH = bfpr_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           func,
	input  logic [7:0]                     rx_byte,
	input  logic                           cfg_valid,
	input  logic [bfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           out_ready,
	input  bfpr_pkg::ctl_cmd_t             cmd,
	output bfpr_pkg::dp_status_t           status,
	output logic                           out_valid,
	output logic [1:0]                     packet_type,
	output logic [3:0]                     sender_id,
	output logic [7:0]                     data_byte,
	output logic [4:0]                     data_count,
	output logic                           is_empty,
	output logic                           last
);

	localparam int FW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [15:0]   id_mask_q;
	logic [15:0]   timeout_q;
	logic [15:0]   idle_q;
	logic [15:0]   idle_next;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] count_q;
	logic [FW-1:0] k_q;
	logic [FW-1:0] rd_addr_full;
	logic [FW+4:0] count_ext;
	logic [1:0]    kind_q;
	logic [1:0]    rx_kind;
	logic [7:0]    idc_q;
	logic [7:0]    id_diff;
	logic          id_ok;
	logic          empty_q;
	logic [3:0]    sid_q;
	logic [7:0]    rd_data;
	logic          out_valid_q;
	logic [1:0]    ptype_q;
	logic [3:0]    osid_q;
	logic [7:0]    obyte_q;
	logic [4:0]    ocount_q;
	logic          oempty_q;
	logic          olast_q;
	logic          closes;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_mask_q <= bfpr_pkg::ID_MASK_RESET;
			timeout_q <= bfpr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == bfpr_pkg::REG_ID_MASK) begin
				id_mask_q <= cfg_data;
			end
			if (cfg_index == bfpr_pkg::REG_TIMEOUT) begin
				timeout_q <= cfg_data;
			end
		end
	end

	// saturating idle tick counter, cleared by any byte
	assign idle_next = (idle_q != bfpr_pkg::IDLE_MAX) ? idle_q + 16'd1 : idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
		end else if (cmd.take) begin
			idle_q <= func ? idle_next : '0;
		end
	end

	// opener decode
	always_comb begin
		rx_kind = bfpr_pkg::KIND_NOTE;
		if (rx_byte == bfpr_pkg::CH_OPEN_ADMIN) begin
			rx_kind = bfpr_pkg::KIND_ADMIN;
		end else if (rx_byte == bfpr_pkg::CH_OPEN_INSTR) begin
			rx_kind = bfpr_pkg::KIND_INSTR;
		end
	end

	// closer matching the bracket that opened the packet
	assign closes = (kind_q == bfpr_pkg::KIND_NOTE  && rx_byte == bfpr_pkg::CH_CLOSE_NOTE)
		|| (kind_q == bfpr_pkg::KIND_ADMIN && rx_byte == bfpr_pkg::CH_CLOSE_ADMIN)
		|| (kind_q == bfpr_pkg::KIND_INSTR && rx_byte == bfpr_pkg::CH_CLOSE_INSTR);

	// id digit check
	assign id_diff = idc_q - bfpr_pkg::CH_ZERO;
	assign id_ok   = (idc_q >= bfpr_pkg::CH_ZERO) && (id_diff < 8'd16)
		&& id_mask_q[id_diff[3:0]];

	// packet framing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			kind_q <= bfpr_pkg::KIND_NOTE;
		end else begin
			if (cmd.start) begin
				fill_q <= FW'(1);
				kind_q <= rx_kind;
			end else if (cmd.clear_fill || cmd.finish) begin
				fill_q <= '0;
			end else if (cmd.store) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// id byte is the first stored byte after the opener
	always_ff @(posedge clk) begin
		if (cmd.store && fill_q == FW'(1)) begin
			idc_q <= rx_byte;
		end
	end

	// packet summary and emission index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			empty_q <= 1'b0;
			sid_q   <= '0;
		end else if (cmd.finish) begin
			count_q <= fill_q - FW'(2);
			k_q     <= '0;
			empty_q <= (fill_q == FW'(2));
			sid_q   <= id_diff[3:0];
		end else if (cmd.k_inc) begin
			k_q <= k_q + FW'(1);
		end
	end

	// payload store, entry index equals the fill count, which includes the opener
	assign rd_addr_full = k_q + FW'(2);

	bfpr_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (cmd.rd_issue),
		.raddr (rd_addr_full[AW-1:0]),
		.rdata (rd_data)
	);

	// output register
	assign count_ext = (FW+5)'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ptype_q  <= kind_q;
			osid_q   <= sid_q;
			obyte_q  <= empty_q ? 8'd0 : rd_data;
			ocount_q <= count_ext[4:0];
			oempty_q <= empty_q;
			olast_q  <= status.last_res;
		end
	end

	// status toward the controller
	always_comb begin
		status.is_tick     = func;
		status.is_opener   = (rx_byte == bfpr_pkg::CH_OPEN_NOTE)
			|| (rx_byte == bfpr_pkg::CH_OPEN_ADMIN) || (rx_byte == bfpr_pkg::CH_OPEN_INSTR);
		status.closes      = closes;
		status.full        = (fill_q >= FW'(BUFFER_DEPTH));
		status.timeout_hit = (idle_next > timeout_q);
		status.pkt_ok      = (fill_q >= FW'(2)) && id_ok;
		status.empty       = (fill_q == FW'(2));
		status.last_res    = empty_q || ((k_q + FW'(1)) == count_q);
		status.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign packet_type = ptype_q;
	assign sender_id   = osid_q;
	assign data_byte   = obyte_q;
	assign data_count  = ocount_q;
	assign is_empty    = oempty_q;
	assign last        = olast_q;

endmodule

// ===== hw/rtl/bfpr_ctrl.sv =====
// controller: hunt, fill and emit sequencing of the packet receiver
`include "bracket_framed_packet_receiver_top_assert.svh"

module bfpr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bfpr_pkg::dp_status_t status,
	output bfpr_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_HUNT = 4'b0001,
		ST_PKT  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_WR   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign in_ready = (state_q == ST_HUNT) || (state_q == ST_PKT);
	assign take     = in_valid && in_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.take = take;
		unique case (state_q)
			ST_HUNT: begin
				if (take && !status.is_tick && status.is_opener) begin
					cmd.start = 1'b1;
					state_d   = ST_PKT;
				end
			end
			ST_PKT: begin
				if (take) begin
					priority if (status.is_tick) begin
						if (status.timeout_hit) begin
							cmd.clear_fill = 1'b1;
							state_d        = ST_HUNT;
						end
					end else if (status.closes) begin
						if (status.pkt_ok) begin
							cmd.finish = 1'b1;
							state_d    = status.empty ? ST_WR : ST_RD;
						end else begin
							cmd.clear_fill = 1'b1;
							state_d        = ST_HUNT;
						end
					end else if (status.full) begin
						cmd.clear_fill = 1'b1;
						state_d        = ST_HUNT;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_WR;
			end
			ST_WR: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.last_res) begin
						state_d = ST_HUNT;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// a store read is always followed by loading its result
	`BFPR_ASSERT_NEXT(a_rd_then_wr, state_q == ST_RD, state_q == ST_WR,
		"store read not followed by output load")
	// a blocked output keeps the emitter waiting
	`BFPR_ASSERT_NEXT(a_wr_stall, state_q == ST_WR && !status.out_free, state_q == ST_WR,
		"emitter left wait state with output still full")
	// a timed out tick inside a packet returns to hunting
	`BFPR_ASSERT_NEXT(a_timeout_drop,
		take && state_q == ST_PKT && status.is_tick && status.timeout_hit,
		state_q == ST_HUNT, "timeout did not drop the partial packet")
	// no input transaction while results are being emitted
	`BFPR_ASSERT_NOW(a_no_take_emit, state_q == ST_RD || state_q == ST_WR, !take,
		"input transaction accepted during emission")

endmodule

// ===== hw/rtl/bracket_framed_packet_receiver_top.sv =====
// Bracket-framed packet receiver. Each input transaction is a received byte or one time tick.
// Bytes between an opener ('[', '{', '(') and its matching closer are kept in a
// BUFFER_DEPTH-entry store memory; the byte after the opener is the sender id digit,
// checked against id_mask. On an accepted close the block stops taking input and gives out
// one result per payload byte, each by a store memory read and then an output register load;
// an empty packet gives a single result by the output register load alone. Input is held
// until the last result is loaded, and the load waits while the output side stalls. A partial
// packet is dropped when the idle tick count exceeds timeout_ticks or when a non-closing byte
// arrives with the store full. The store needs no clearing after reset. Configuration writes
// are taken in any cycle; index 0 is id_mask, index 1 timeout_ticks, other indexes ignored.
module bracket_framed_packet_receiver_top #(
	parameter int BUFFER_DEPTH = bfpr_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [7:0]                     rx_byte,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     packet_type,
	output logic [3:0]                     sender_id,
	output logic [7:0]                     data_byte,
	output logic [4:0]                     data_count,
	output logic                           is_empty,
	output logic                           last,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	bfpr_pkg::ctl_cmd_t   cmd;
	bfpr_pkg::dp_status_t status;

	// registers accept every configuration transaction at once
	assign cfg_ready = 1'b1;

	bfpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bfpr_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.packet_type (packet_type),
		.sender_id   (sender_id),
		.data_byte   (data_byte),
		.data_count  (data_count),
		.is_empty    (is_empty),
		.last        (last)
	);

endmodule

// ===== tb/tb_bracket_framed_packet_receiver_top.sv =====
// self-checking testbench for the bracket framed packet receiver
`timescale 1ns / 100ps

module tb_bracket_framed_packet_receiver_top;

	localparam int STORE_DEPTH = bfpr_pkg::BUFFER_DEPTH_DEF;
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int QUIET_CYCLES = 80;

	typedef struct {
		logic       is_tick;
		logic [7:0] b;
	} rx_item_t;

	typedef struct {
		logic [1:0] kind;
		logic [3:0] id;
		logic [7:0] data;
		logic [4:0] count;
		logic       no_data;
		logic       is_last;
	} packet_result_t;

	// dut signals, inputs all known from time zero
	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           func = FUNC_BYTE;
	logic [7:0]                     rx_byte = 8'h00;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     packet_type;
	logic [3:0]                     sender_id;
	logic [7:0]                     data_byte;
	logic [4:0]                     data_count;
	logic                           is_empty;
	logic                           last;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [bfpr_pkg::CFG_IDX_W-1:0] cfg_index = bfpr_pkg::REG_ID_MASK;
	logic [15:0]                    cfg_data = 16'h0000;

	// stimulus and expected result stores
	rx_item_t       rx_stream[$];
	packet_result_t packet_results_due[$];
	int unsigned    items_queued = 0;
	int unsigned    mismatches = 0;
	int unsigned    send_idle_max = 0;
	int unsigned    recv_idle_max = 0;
	int unsigned    send_gap = 0;
	int unsigned    hold_cnt = 0;
	bit             hold_off_request = 1'b0;
	bit             hold_off_taken = 1'b0;

	// receiver state as the testbench tracks it
	logic [15:0] accept_mask = bfpr_pkg::ID_MASK_RESET;
	logic [15:0] drop_after_ticks = bfpr_pkg::TIMEOUT_RESET;
	logic        framing = 1'b0;
	logic [1:0]  frame_kind = bfpr_pkg::KIND_NOTE;
	int unsigned frame_fill = 0;
	logic [15:0] idle_ticks = 16'd0;
	logic [7:0]  frame_mem[STORE_DEPTH];

	bracket_framed_packet_receiver_top #(.BUFFER_DEPTH(STORE_DEPTH)) uut (.*);

	always #4 clk = ~clk;

	// advance the framing state by one byte or tick, queue any packet bytes it releases
	function automatic void track_framing(logic is_tick, logic [7:0] b);
		logic           closes;
		logic [7:0]     digit;
		int unsigned    n_data;
		packet_result_t r;
		if (is_tick) begin
			if (idle_ticks != bfpr_pkg::IDLE_MAX)
				idle_ticks++;
			if (framing && idle_ticks > drop_after_ticks) begin
				framing = 1'b0;
				frame_fill = 0;
			end
			return;
		end
		idle_ticks = 16'd0;
		// hunting: only an opener starts a frame
		if (!framing) begin
			case (b)
				bfpr_pkg::CH_OPEN_NOTE: frame_kind = bfpr_pkg::KIND_NOTE;
				bfpr_pkg::CH_OPEN_ADMIN: frame_kind = bfpr_pkg::KIND_ADMIN;
				bfpr_pkg::CH_OPEN_INSTR: frame_kind = bfpr_pkg::KIND_INSTR;
				default: return;
			endcase
			framing = 1'b1;
			frame_mem[0] = b;
			frame_fill = 1;
			return;
		end
		closes = (frame_kind == bfpr_pkg::KIND_NOTE && b == bfpr_pkg::CH_CLOSE_NOTE)
			|| (frame_kind == bfpr_pkg::KIND_ADMIN && b == bfpr_pkg::CH_CLOSE_ADMIN)
			|| (frame_kind == bfpr_pkg::KIND_INSTR && b == bfpr_pkg::CH_CLOSE_INSTR);
		if (!closes) begin
			// a byte with the store full kills the frame and is swallowed
			if (frame_fill >= STORE_DEPTH) begin
				framing = 1'b0;
				frame_fill = 0;
			end else begin
				frame_mem[frame_fill] = b;
				frame_fill++;
			end
			return;
		end
		// matching close: check id byte and mask
		framing = 1'b0;
		n_data = frame_fill - 2;
		if (frame_fill < 2) begin
			frame_fill = 0;
			return;
		end
		frame_fill = 0;
		digit = frame_mem[1] - bfpr_pkg::CH_ZERO;
		if (frame_mem[1] < bfpr_pkg::CH_ZERO || digit > 8'd15 || !accept_mask[digit[3:0]])
			return;
		r.kind = frame_kind;
		r.id = digit[3:0];
		if (n_data == 0) begin
			r.data = 8'h00;
			r.count = 5'd0;
			r.no_data = 1'b1;
			r.is_last = 1'b1;
			packet_results_due.push_back(r);
			return;
		end
		for (int k = 0; k < n_data; k++) begin
			r.data = frame_mem[k + 2];
			r.count = n_data[4:0];
			r.no_data = 1'b0;
			r.is_last = (k == n_data - 1);
			packet_results_due.push_back(r);
		end
	endfunction

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// input driver: one transaction at a time from the stream queue
	always @(posedge clk or negedge arst_n) begin : rx_driver
		rx_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_BYTE;
			rx_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				track_framing(func, rx_byte);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (rx_stream.size() != 0) begin
					nxt = rx_stream.pop_front();
					in_valid <= 1'b1;
					func <= nxt.is_tick;
					rx_byte <= nxt.b;
					send_gap <= $urandom_range(0, send_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random and long output stalls
	always @(posedge clk or negedge arst_n) begin : result_monitor
		packet_result_t want;
		int unsigned    wait_n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			wait_n = (hold_cnt != 0) ? hold_cnt - 1 : 0;
			if (out_valid && out_ready) begin
				if (packet_results_due.size() == 0) begin
					$display("%0t: unexpected result type %0d id %0d data %0d", $time,
						packet_type, sender_id, data_byte);
					mismatches++;
				end else begin
					want = packet_results_due.pop_front();
					check_field("packet_type", 8'(want.kind), 8'(packet_type));
					check_field("sender_id", 8'(want.id), 8'(sender_id));
					check_field("data_count", 8'(want.count), 8'(data_count));
					check_field("is_empty", 8'(want.no_data), 8'(is_empty));
					check_field("last", 8'(want.is_last), 8'(last));
					if (!want.no_data)
						check_field("data_byte", want.data, data_byte);
				end
				wait_n = $urandom_range(0, recv_idle_max);
			end
			if (hold_off_request && !hold_off_taken) begin
				wait_n = LONG_HOLD_CYCLES;
				hold_off_taken <= 1'b1;
			end
			hold_cnt <= wait_n;
			out_ready <= (wait_n == 0);
		end
	end

	task automatic queue_item(logic is_tick, logic [7:0] b);
		rx_item_t it;
		it.is_tick = is_tick;
		it.b = b;
		rx_stream.push_back(it);
		items_queued++;
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_item(FUNC_BYTE, s[i]);
	endtask

	// one frame with random payload, optional idle ticks and a stray closer
	task automatic queue_frame(logic [1:0] kind, bit has_id, logic [7:0] idc, int n_data,
			int tick_span, bit stray_close);
		logic [7:0] opener;
		logic [7:0] closer;
		logic [7:0] stray;
		logic [7:0] b;
		case (kind)
			bfpr_pkg::KIND_NOTE: begin
				opener = bfpr_pkg::CH_OPEN_NOTE;
				closer = bfpr_pkg::CH_CLOSE_NOTE;
				stray = bfpr_pkg::CH_CLOSE_ADMIN;
			end
			bfpr_pkg::KIND_ADMIN: begin
				opener = bfpr_pkg::CH_OPEN_ADMIN;
				closer = bfpr_pkg::CH_CLOSE_ADMIN;
				stray = bfpr_pkg::CH_CLOSE_INSTR;
			end
			default: begin
				opener = bfpr_pkg::CH_OPEN_INSTR;
				closer = bfpr_pkg::CH_CLOSE_INSTR;
				stray = bfpr_pkg::CH_CLOSE_NOTE;
			end
		endcase
		queue_item(FUNC_BYTE, opener);
		if (has_id)
			queue_item(FUNC_BYTE, idc);
		for (int i = 0; i < n_data; i++) begin
			if (tick_span != 0 && $urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, tick_span))
					queue_item(FUNC_TICK, 8'($urandom_range(0, 255)));
			b = 8'($urandom_range(0, 255));
			// framing characters as payload now and then
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 6))
					0: b = bfpr_pkg::CH_OPEN_NOTE;
					1: b = bfpr_pkg::CH_OPEN_ADMIN;
					2: b = bfpr_pkg::CH_OPEN_INSTR;
					3: b = bfpr_pkg::CH_CLOSE_NOTE;
					4: b = bfpr_pkg::CH_CLOSE_ADMIN;
					5: b = bfpr_pkg::CH_CLOSE_INSTR;
					default: b = bfpr_pkg::CH_DOT;
				endcase
			end
			if (b == closer)
				b = bfpr_pkg::CH_DOT;
			queue_item(FUNC_BYTE, b);
		end
		if (stray_close)
			queue_item(FUNC_BYTE, stray);
		if (tick_span != 0 && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, tick_span))
				queue_item(FUNC_TICK, 8'($urandom_range(0, 255)));
		queue_item(FUNC_BYTE, closer);
	endtask

	// mostly well-formed frames, some noise, missing ids and bad ids
	task automatic queue_random_run(int unsigned n_items, int tick_span);
		int unsigned start;
		int          pick;
		int          sel;
		int          n_data;
		logic [7:0]  idc;
		start = items_queued;
		while (items_queued - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 4))
					queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 7)
					n_data = $urandom_range(0, 6);
				else if (sel < 9)
					n_data = $urandom_range(7, 29);
				else
					n_data = $urandom_range(30, 31);
				if ($urandom_range(0, 5) == 0)
					idc = 8'($urandom_range(0, 255));
				else
					idc = bfpr_pkg::CH_ZERO + 8'($urandom_range(0, 15));
				queue_frame(2'($urandom_range(0, 2)), pick >= 15, idc, n_data, tick_span,
					$urandom_range(0, 9) == 0);
			end
		end
	endtask

	task automatic write_reg(logic [bfpr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == bfpr_pkg::REG_ID_MASK)
			accept_mask = val;
		else if (idx == bfpr_pkg::REG_TIMEOUT)
			drop_after_ticks = val;
	endtask

	// sender pauses until every result is out and the block has gone quiet
	task automatic wait_quiet();
		@(negedge clk);
		while (rx_stream.size() != 0 || in_valid || packet_results_due.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	initial begin : test_sequence
		logic [15:0] t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// mask all clear: every packet dropped
		write_reg(bfpr_pkg::REG_ID_MASK, 16'h0000);
		@(negedge clk);
		queue_text("[5x]");
		wait_quiet();

		// directed frames with every id accepted and the shortest timeout
		write_reg(bfpr_pkg::REG_ID_MASK, 16'hFFFF);
		write_reg(bfpr_pkg::REG_TIMEOUT, 16'd1);
		@(negedge clk);
		send_idle_max = 19;
		recv_idle_max = 19;
		queue_text("[0]");
		queue_text("{?");
		queue_item(FUNC_BYTE, 8'h00);
		queue_item(FUNC_BYTE, 8'hFF);
		queue_text("}");
		queue_text("(5.[})");
		queue_text("[]");
		queue_text("a");
		queue_text("[@]");
		// one idle tick is allowed, two drop the frame
		queue_text("[3");
		queue_item(FUNC_TICK, 8'hFF);
		queue_text("b]");
		queue_text("(1");
		queue_item(FUNC_TICK, 8'h00);
		queue_item(FUNC_TICK, 8'hA5);
		queue_text(")");
		wait_quiet();

		// random mask, short timeouts, random idling on both sides
		write_reg(bfpr_pkg::REG_ID_MASK, 16'($urandom_range(0, 65535)));
		t = 16'($urandom_range(1, 4));
		write_reg(bfpr_pkg::REG_TIMEOUT, t);
		@(negedge clk);
		queue_random_run(60, t + 2);
		wait_quiet();

		// longest timeout, no idling at all
		write_reg(bfpr_pkg::REG_ID_MASK, 16'hFFFF);
		write_reg(bfpr_pkg::REG_TIMEOUT, 16'hFFFF);
		@(negedge clk);
		send_idle_max = 0;
		recv_idle_max = 0;
		queue_random_run(60, 6);
		wait_quiet();

		// output held off while full frames keep arriving
		write_reg(bfpr_pkg::REG_TIMEOUT, bfpr_pkg::TIMEOUT_RESET);
		@(negedge clk);
		recv_idle_max = 3;
		queue_frame(bfpr_pkg::KIND_NOTE, 1'b1, bfpr_pkg::CH_ZERO + 8'd7, 30, 0, 1'b0);
		queue_frame(bfpr_pkg::KIND_ADMIN, 1'b1, bfpr_pkg::CH_ZERO + 8'd15, 30, 0, 1'b0);
		hold_off_request = 1'b1;
		queue_random_run(35, 3);
		wait_quiet();

		// sparse mask, small random timeout, mixed idling
		write_reg(bfpr_pkg::REG_ID_MASK,
			16'(($urandom_range(0, 65535) & $urandom_range(0, 65535)) | 1));
		t = 16'($urandom_range(1, 8));
		write_reg(bfpr_pkg::REG_TIMEOUT, t);
		@(negedge clk);
		send_idle_max = 19;
		recv_idle_max = 19;
		queue_random_run(60, t + 2);
		wait_quiet();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bfpr_pkg.sv
hw/rtl/bfpr_ram.sv
hw/rtl/bfpr_datapath.sv
hw/rtl/bfpr_ctrl.sv
hw/rtl/bracket_framed_packet_receiver_top.sv
tb/tb_bracket_framed_packet_receiver_top.sv
